// ----- sv/nsca_pkg.sv -----
// Shared types, constants and helper functions for the seed clustering block.
`default_nettype none

package nsca_pkg;

    // Point space and neighbor list limits.
    localparam int NUM_POINTS = 4096;
    localparam int MAX_K      = 16;

    // Field widths fixed by the stream format.
    localparam int POINT_W    = 12;
    localparam int LABEL_W    = 11;
    localparam int CLUSTER_W  = 12;
    localparam int KIND_W     = 2;
    localparam int CFG_W      = 5;
    localparam int LABEL_LIMIT = 2048;

    // Derived storage widths.
    localparam int ADDR_W  = $clog2(NUM_POINTS);
    localparam int WORD_W  = LABEL_W + 1;
    localparam int CNT_W   = $clog2(MAX_K + 1);
    localparam int BUF_AW  = $clog2(MAX_K);
    localparam bit ADDR_IS_MASK = (NUM_POINTS >= (1 << POINT_W)) ||
                                  ((NUM_POINTS & (NUM_POINTS - 1)) == 0);

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_CLEARED     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEED_MEMBER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROVISIONAL = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SKIPPED     = 2'd3;

    // Input operations.
    localparam logic OP_CLEAR    = 1'b0;
    localparam logic OP_NEIGHBOR = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_CLUSTER_SIZE    = 1'b0;
    localparam logic CFG_LABEL_LEFTOVERS = 1'b1;

    // One access to the point memory: a read or a write of one entry.
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wr_data;
    } mem_req_t;

    // Maps a point index onto a point memory address (index modulo NUM_POINTS).
    function automatic logic [ADDR_W-1:0] point_addr(input logic [POINT_W-1:0] p);
        logic [31:0] t;
        t = 32'(p);
        if (!ADDR_IS_MASK) begin
            // Restoring reduction, one shifted subtract per index bit.
            for (int s = POINT_W - 1; s >= 0; s--) begin
                if (t >= (32'(NUM_POINTS) << s)) begin
                    t = t - (32'(NUM_POINTS) << s);
                end
            end
        end
        return ADDR_W'(t);
    endfunction

    // Clamps the cluster size register into the supported range.
    function automatic logic [CNT_W-1:0] clamp_k(input logic [CFG_W-1:0] cs);
        logic [CNT_W-1:0] k;
        if (cs < CFG_W'(2)) begin
            k = CNT_W'(2);
        end else if (32'(cs) > 32'(MAX_K)) begin
            k = CNT_W'(MAX_K);
        end else begin
            k = CNT_W'(cs);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- sv/nsca_point_ram.sv -----
// Single-port point memory holding the assigned flag and label of every point.
`default_nettype none

module nsca_point_ram (
    input  wire logic                        aclk,
    input  wire nsca_pkg::mem_req_t          req,
    output logic [nsca_pkg::WORD_W-1:0]      rd_data
);

    // Entry layout: assigned flag on top, label below.
    logic [nsca_pkg::WORD_W-1:0] point_mem [nsca_pkg::NUM_POINTS];
    logic [nsca_pkg::WORD_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            point_mem[req.addr] <= req.wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= point_mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/nsca_nbr_buf.sv -----
// Buffer of the neighbors received so far for the current query.
`default_nettype none

module nsca_nbr_buf (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [nsca_pkg::BUF_AW-1:0]   wr_idx,
    input  wire logic [nsca_pkg::POINT_W-1:0]  wr_data,
    input  wire logic [nsca_pkg::BUF_AW-1:0]   rd_idx,
    output logic [nsca_pkg::POINT_W-1:0]       rd_data
);

    logic [nsca_pkg::POINT_W-1:0] buf_reg [nsca_pkg::MAX_K];

    // Neighbors are stored in arrival order.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_reg[wr_idx] <= wr_data;
        end
    end

    // Cluster members are read back one per cycle while the result side accepts them.
    assign rd_data = buf_reg[rd_idx];

endmodule

`default_nettype wire

// ----- sv/nng_seed_cluster_assign.sv -----
// Top level of the greedy seed clustering block over a streamed neighbor graph.
//
// Each input item carries one neighbor of a query point, nearest first; a list
// ends on tlast or on its K-th item. All point state (assigned flag and label)
// lives in one single-port memory with a registered read, and every item goes
// through it one access at a time. A neighbor that does not end its list is
// looked up and buffered; a list end then looks up the query itself and, for a
// seed, makes one memory write and one result per cluster member. The decision
// and the member writes wait while the result side stalls.
// A clear item gives its result and then sweeps the point memory, one entry per
// cycle, over all NUM_POINTS (4096) entries, during which no item is accepted;
// the same sweep runs after reset. Configuration writes are taken at any time.
`default_nettype none

module nng_seed_cluster_assign (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write port.
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_index,
    input  wire logic [4:0]   cfg_wr_data,
    // Input stream.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // query_point[11:0], neighbor_point[23:12]
    input  wire logic         s_tuser,   // op
    input  wire logic         s_tlast,   // last_neighbor
    // Result stream.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,   // point[11:0], label[22:12],
                                         // clusters_made[34:23], zero[39:35]
    output logic [1:0]        m_tuser,   // kind
    output logic              m_tlast    // last_result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NB    = 3'd1;
    localparam logic [2:0] ST_DEC   = 3'd2;
    localparam logic [2:0] ST_SEED  = 3'd3;
    localparam logic [2:0] ST_CLR   = 3'd4;
    localparam logic [2:0] ST_SWEEP = 3'd5;

    // Control state.
    logic [2:0]                       state_reg, state_next;
    logic [nsca_pkg::ADDR_W-1:0]      sweep_reg, sweep_next;
    logic [nsca_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [nsca_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic                             found_reg, found_next;
    logic                             self_reg, self_next;
    logic [nsca_pkg::LABEL_W-1:0]     first_lab_reg, first_lab_next;
    logic [nsca_pkg::CLUSTER_W-1:0]   clusters_reg, clusters_next;
    logic [nsca_pkg::CFG_W-1:0]       csize_reg;
    logic                             leftovers_reg;

    // Captured item and seed label.
    logic [nsca_pkg::POINT_W-1:0]     q_reg, q_next;
    logic [nsca_pkg::POINT_W-1:0]     nb_reg, nb_next;
    logic                             last_reg, last_next;
    logic [nsca_pkg::LABEL_W-1:0]     lab_reg, lab_next;

    // Output register.
    logic                             m_valid_reg, m_valid_next;
    logic [nsca_pkg::KIND_W-1:0]      o_kind_reg, o_kind_next;
    logic [nsca_pkg::POINT_W-1:0]     o_point_reg, o_point_next;
    logic [nsca_pkg::LABEL_W-1:0]     o_label_reg, o_label_next;
    logic                             o_last_reg, o_last_next;
    logic [nsca_pkg::CLUSTER_W-1:0]   o_clusters_reg, o_clusters_next;

    // Memory and buffer connections.
    nsca_pkg::mem_req_t               mem_req;
    logic [nsca_pkg::WORD_W-1:0]      mem_rd_data;
    logic                             buf_wr_en;
    logic [nsca_pkg::BUF_AW-1:0]      buf_wr_idx;
    logic [nsca_pkg::POINT_W-1:0]     buf_rd_data;

    // Helpers.
    logic                             accept;
    logic                             out_free;
    logic                             rd_flag;
    logic [nsca_pkg::LABEL_W-1:0]     rd_label;
    logic [nsca_pkg::CNT_W-1:0]       k_eff;
    logic                             list_drop;
    logic [nsca_pkg::CNT_W-1:0]       cnt_eff;
    logic                             found_eff;
    logic                             is_final;
    logic [nsca_pkg::POINT_W-1:0]     member;

    nsca_point_ram u_point_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    nsca_nbr_buf u_nbr_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_idx  (buf_wr_idx),
        .wr_data (nb_reg),
        .rd_idx  (idx_reg[nsca_pkg::BUF_AW-1:0]),
        .rd_data (buf_rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign rd_flag  = mem_rd_data[nsca_pkg::LABEL_W];
    assign rd_label = mem_rd_data[nsca_pkg::LABEL_W-1:0];
    assign k_eff    = nsca_pkg::clamp_k(csize_reg);

    // A list left over from a larger cluster size is dropped before use.
    assign list_drop = (cnt_reg >= k_eff);
    assign cnt_eff   = list_drop ? '0 : cnt_reg;
    assign found_eff = list_drop ? 1'b0 : found_reg;
    assign is_final  = last_reg ||
                       ({1'b0, cnt_eff} + (nsca_pkg::CNT_W + 1)'(1) >= {1'b0, k_eff});
    assign buf_wr_idx = cnt_eff[nsca_pkg::BUF_AW-1:0];

    // The tail member is the last neighbor when the query is already among the others.
    assign member = (idx_reg == cnt_reg) ? (self_reg ? nb_reg : q_reg) : buf_rd_data;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csize_reg     <= nsca_pkg::CFG_W'(2);
            leftovers_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                nsca_pkg::CFG_CLUSTER_SIZE:    csize_reg     <= cfg_wr_data;
                nsca_pkg::CFG_LABEL_LEFTOVERS: leftovers_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer: neighbor lookup, query decision, member writes and clear sweep.
    always_comb begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        self_next       = self_reg;
        first_lab_next  = first_lab_reg;
        clusters_next   = clusters_reg;
        q_next          = q_reg;
        nb_next         = nb_reg;
        last_next       = last_reg;
        lab_next        = lab_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        o_kind_next     = o_kind_reg;
        o_point_next    = o_point_reg;
        o_label_next    = o_label_reg;
        o_last_next     = o_last_reg;
        o_clusters_next = o_clusters_reg;
        mem_req         = '0;
        buf_wr_en       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    q_next    = s_tdata[11:0];
                    nb_next   = s_tdata[23:12];
                    last_next = s_tlast;
                    if (s_tuser == nsca_pkg::OP_CLEAR) begin
                        clusters_next  = '0;
                        cnt_next       = '0;
                        found_next     = 1'b0;
                        self_next      = 1'b0;
                        first_lab_next = '0;
                        state_next     = ST_CLR;
                    end else begin
                        // Look up the neighbor's flag and label.
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = nsca_pkg::point_addr(s_tdata[23:12]);
                        state_next    = ST_NB;
                    end
                end
            end

            ST_NB: begin
                found_next = found_eff || rd_flag;
                if (rd_flag && !found_eff) begin
                    first_lab_next = rd_label;
                end else if (list_drop) begin
                    first_lab_next = '0;
                end
                if (list_drop) begin
                    self_next = 1'b0;
                end
                if (!is_final) begin
                    buf_wr_en  = 1'b1;
                    cnt_next   = cnt_eff + nsca_pkg::CNT_W'(1);
                    if (nb_reg == q_reg) begin
                        self_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end else begin
                    // Look up the query itself.
                    cnt_next      = cnt_eff;
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = nsca_pkg::point_addr(q_reg);
                    state_next    = ST_DEC;
                end
            end

            ST_DEC: begin
                if (out_free) begin
                    if (!rd_flag && !found_reg &&
                        (clusters_reg < nsca_pkg::CLUSTER_W'(nsca_pkg::LABEL_LIMIT))) begin
                        // Seed: open a new cluster and write its members.
                        lab_next      = clusters_reg[nsca_pkg::LABEL_W-1:0];
                        clusters_next = clusters_reg + nsca_pkg::CLUSTER_W'(1);
                        idx_next      = '0;
                        state_next    = ST_SEED;
                    end else begin
                        m_valid_next    = 1'b1;
                        o_point_next    = q_reg;
                        o_last_next     = 1'b1;
                        o_clusters_next = clusters_reg;
                        o_kind_next     = nsca_pkg::KIND_SKIPPED;
                        o_label_next    = '0;
                        if (!rd_flag && found_reg && leftovers_reg) begin
                            o_kind_next     = nsca_pkg::KIND_PROVISIONAL;
                            o_label_next    = first_lab_reg;
                            mem_req.wr_en   = 1'b1;
                            mem_req.addr    = nsca_pkg::point_addr(q_reg);
                            mem_req.wr_data = {1'b0, first_lab_reg};
                        end
                        cnt_next       = '0;
                        found_next     = 1'b0;
                        self_next      = 1'b0;
                        first_lab_next = '0;
                        state_next     = ST_IDLE;
                    end
                end
            end

            ST_SEED: begin
                if (out_free) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.addr    = nsca_pkg::point_addr(member);
                    mem_req.wr_data = {1'b1, lab_reg};
                    m_valid_next    = 1'b1;
                    o_kind_next     = nsca_pkg::KIND_SEED_MEMBER;
                    o_point_next    = member;
                    o_label_next    = lab_reg;
                    o_clusters_next = clusters_reg;
                    o_last_next     = (idx_reg == cnt_reg);
                    if (idx_reg == cnt_reg) begin
                        cnt_next       = '0;
                        found_next     = 1'b0;
                        self_next      = 1'b0;
                        first_lab_next = '0;
                        state_next     = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + nsca_pkg::CNT_W'(1);
                    end
                end
            end

            ST_CLR: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    o_kind_next     = nsca_pkg::KIND_CLEARED;
                    o_point_next    = '0;
                    o_label_next    = '0;
                    o_last_next     = 1'b1;
                    o_clusters_next = clusters_reg;
                    sweep_next      = '0;
                    state_next      = ST_SWEEP;
                end
            end

            ST_SWEEP: begin
                // Clear one assigned flag per cycle.
                mem_req.wr_en   = 1'b1;
                mem_req.addr    = sweep_reg;
                mem_req.wr_data = '0;
                if (sweep_reg == nsca_pkg::ADDR_W'(nsca_pkg::NUM_POINTS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + nsca_pkg::ADDR_W'(1);
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            self_reg      <= 1'b0;
            first_lab_reg <= '0;
            clusters_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            self_reg      <= self_next;
            first_lab_reg <= first_lab_next;
            clusters_reg  <= clusters_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        q_reg          <= q_next;
        nb_reg         <= nb_next;
        last_reg       <= last_next;
        lab_reg        <= lab_next;
        o_kind_reg     <= o_kind_next;
        o_point_reg    <= o_point_next;
        o_label_reg    <= o_label_next;
        o_last_reg     <= o_last_next;
        o_clusters_reg <= o_clusters_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, o_clusters_reg, o_label_reg, o_point_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire
